>>> rtl/core/ptss_pkg.sv
package ptss_pkg;

  localparam int NUM_PARENTS = 16;
  localparam int PID_W = 4;
  localparam int SLOT_W = 4;
  localparam int NSLOT = 16;
  localparam int CNT_W = 5;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_PARENT = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  // queued request between front and back
  typedef struct packed {
    action_t           action;
    logic [PID_W-1:0]  parent_id;
    logic [SLOT_W-1:0] slot;
  } req_t;

  // clamp the configured shift into the supported range
  function automatic logic [3:0] eff_shift(input logic [3:0] sh);
    logic [3:0] r;
    if (sh < 4'd8) begin
      r = 4'd8;
    end else if (sh > 4'd11) begin
      r = 4'd11;
    end else begin
      r = sh;
    end
    return r;
  endfunction

  // all-free mask for the slot count at a clamped shift
  function automatic logic [NSLOT-1:0] full_mask(input logic [3:0] sh);
    logic [NSLOT-1:0] m;
    case (sh)
      4'd8:    m = 16'hFFFF;
      4'd9:    m = 16'h00FF;
      4'd10:   m = 16'h000F;
      default: m = 16'h0003;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/ptss_front.sv
module ptss_front import ptss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  req_t              in_req,
  output logic              in_full,
  input  logic              deq,
  output logic              q_valid,
  output req_t              q_req
);

  req_t             q_r [QDEPTH];
  logic [1:0]       cnt_r;
  logic             rd_r;
  logic             wr_r;

  assign in_full = (cnt_r == 2'(QDEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = q_r[rd_r];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (in_valid && !in_full) begin
        q_r[wr_r] <= in_req;
        wr_r <= ~wr_r;
      end
      if (deq) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(in_valid && !in_full) - 2'(deq);
    end
  end

endmodule

>>> rtl/core/ptss_back.sv
module ptss_back import ptss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        sub_shift,
  input  logic              q_valid,
  input  req_t              q_req,
  output logic              deq,
  output logic              res_valid,
  output status_t           res_status,
  output logic [PID_W-1:0]  res_parent,
  output logic [SLOT_W-1:0] res_slot,
  output logic [11:0]       res_offset,
  output logic              res_opened,
  output logic              res_closed
);

  logic [NSLOT-1:0]  free_r [NUM_PARENTS];
  logic [NSLOT-1:0]  free_nxt [NUM_PARENTS];
  logic [PID_W-1:0]  ord_r [NUM_PARENTS];
  logic [PID_W-1:0]  ord_nxt [NUM_PARENTS];
  logic [NUM_PARENTS-1:0] live_r, live_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              vld_r;
  status_t           st_r, st_nxt;
  logic [PID_W-1:0]  p_r, p_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic [11:0]       off_r, off_nxt;
  logic              op_r, op_nxt, cl_r, cl_nxt;

  logic [3:0]        sh;
  logic [NSLOT-1:0]  fm;
  logic [NSLOT-1:0]  bits, nb;
  logic              found;
  logic [PID_W-1:0]  pf;
  logic              rm, push;
  logic [PID_W-1:0]  rm_pid;
  logic              hit;
  logic [PID_W-1:0]  hit_idx;

  assign deq        = q_valid;
  assign res_valid  = vld_r;
  assign res_status = st_r;
  assign res_parent = p_r;
  assign res_slot   = s_r;
  assign res_offset = off_r;
  assign res_opened = op_r;
  assign res_closed = cl_r;

  // execute one request per cycle
  always_comb begin
    sh = eff_shift(sub_shift);
    fm = full_mask(sh);
    free_nxt = free_r;
    ord_nxt  = ord_r;
    live_nxt = live_r;
    cnt_nxt  = cnt_r;
    st_nxt = ST_OK; p_nxt = '0; s_nxt = '0; off_nxt = '0;
    op_nxt = 1'b0; cl_nxt = 1'b0;
    bits = '0; nb = '0; found = 1'b0; pf = '0;
    rm = 1'b0; push = 1'b0; rm_pid = '0; hit = 1'b0; hit_idx = '0;
    // lowest unused parent
    for (int i = NUM_PARENTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        found = 1'b1;
        pf = PID_W'(i);
      end
    end
    if (q_valid) begin
      if (q_req.action == ACT_GET) begin
        if (cnt_r == '0 && !found) begin
          st_nxt = ST_NO_PARENT;
        end else begin
          if (cnt_r == '0) begin
            p_nxt = pf;
            bits = fm;
            op_nxt = 1'b1;
            live_nxt[pf] = 1'b1;
          end else begin
            p_nxt = ord_r[0];
            bits = free_r[ord_r[0]];
          end
          for (int b = NSLOT - 1; b >= 0; b--) begin
            if (bits[b]) s_nxt = SLOT_W'(b);
          end
          nb = bits & ~(NSLOT'(1) << s_nxt);
          free_nxt[p_nxt] = nb;
          off_nxt = 12'(16'(s_nxt) << sh);
          // opened parent sits at head, so removal always pops entry 0
          if (nb == '0) begin
            if (cnt_r == '0) begin
              cnt_nxt = cnt_r;
            end else begin
              rm = 1'b1;
              rm_pid = p_nxt;
            end
          end else if (cnt_r == '0) begin
            ord_nxt[0] = pf;
            cnt_nxt = CNT_W'(1);
          end
        end
      end else begin
        bits = free_r[q_req.parent_id];
        if (!live_r[q_req.parent_id] || (fm[q_req.slot] == 1'b0) ||
            bits[q_req.slot]) begin
          st_nxt = ST_BAD_RELEASE;
        end else begin
          p_nxt = q_req.parent_id;
          s_nxt = q_req.slot;
          off_nxt = 12'(16'(s_nxt) << sh);
          nb = bits | (NSLOT'(1) << s_nxt);
          free_nxt[p_nxt] = nb;
          push = (bits == '0);
          if (nb == fm) begin
            cl_nxt = 1'b1;
            live_nxt[p_nxt] = 1'b0;
            free_nxt[p_nxt] = '0;
            if (!push) begin
              rm = 1'b1;
              rm_pid = p_nxt;
            end
          end else if (push && cnt_r < CNT_W'(NUM_PARENTS)) begin
            for (int i = 1; i < NUM_PARENTS; i++) begin
              ord_nxt[i] = ord_r[i-1];
            end
            ord_nxt[0] = p_nxt;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      // remove a parent from the list by match and shift down
      if (rm) begin
        for (int i = NUM_PARENTS - 1; i >= 0; i--) begin
          if (CNT_W'(i) < cnt_r && ord_r[i] == rm_pid) begin
            hit = 1'b1;
            hit_idx = PID_W'(i);
          end
        end
        if (hit) begin
          for (int i = 0; i < NUM_PARENTS - 1; i++) begin
            if (PID_W'(i) >= hit_idx) ord_nxt[i] = ord_r[i+1];
          end
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      cnt_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      live_r <= live_nxt;
      cnt_r  <= cnt_nxt;
      vld_r  <= q_valid;
    end
    free_r <= free_nxt;
    ord_r  <= ord_nxt;
    st_r   <= st_nxt;
    p_r    <= p_nxt;
    s_r    <= s_nxt;
    off_r  <= off_nxt;
    op_r   <= op_nxt;
    cl_r   <= cl_nxt;
  end

endmodule

>>> rtl/core/page_table_slot_suballocator.sv
// Slot sub-allocator for page tables carved from 4 KiB parent pages. Raise
// start with an item while busy is low; busy rises when the two-entry
// request queue is full. Each item passes through the request queue and the
// back-end result register and is shown for one cycle with out_valid; the
// receiver cannot stall and a result must be taken when it appears. The back
// end retires one item per cycle, so busy stays low under a steady stream.
// Write cfg_wdata only while no item is outstanding.
module page_table_slot_suballocator import ptss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [3:0]  in_parent_id,
  input  logic [3:0]  in_slot,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_granted_parent,
  output logic [3:0]  out_granted_slot,
  output logic [11:0] out_byte_offset,
  output logic        out_parent_opened,
  output logic        out_parent_closed
);

  logic [3:0] shift_r;
  req_t       in_req, q_req;
  logic       q_valid, deq;
  status_t    st;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 4'd8;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  assign in_req = '{action: action_t'(in_action), parent_id: in_parent_id, slot: in_slot};
  assign out_status = st;

  ptss_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .in_req(in_req), .in_full(busy),
    .deq(deq), .q_valid(q_valid), .q_req(q_req)
  );

  ptss_back u_back (
    .clk(clk), .rst_n(rst_n), .sub_shift(shift_r), .q_valid(q_valid), .q_req(q_req),
    .deq(deq), .res_valid(out_valid), .res_status(st),
    .res_parent(out_granted_parent), .res_slot(out_granted_slot),
    .res_offset(out_byte_offset), .res_opened(out_parent_opened),
    .res_closed(out_parent_closed)
  );

`ifndef NO_ASSERTIONS
  // a refused result must carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_parent == 4'd0 &&
    out_byte_offset == 12'd0 && !out_parent_opened && !out_parent_closed)
    else $error("error result with payload");
  // a get never closes and a put never opens, so no result both opens and closes
  a_open_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_parent_opened && out_parent_closed))
    else $error("open and close together");
  // a queued item always leads to a result next cycle
  a_retire: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |=> out_valid)
    else $error("item lost");
`endif

endmodule

>>> test/tb_page_table_slot_suballocator.sv
module tb_page_table_slot_suballocator;
  import ptss_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 250;

  typedef struct packed {
    action_t    action;
    logic [3:0] parent_id;
    logic [3:0] slot;
  } alloc_req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  parent;
    logic [3:0]  slot;
    logic [11:0] offset;
    logic        opened;
    logic        closed;
  } alloc_resp_t;

  typedef struct {
    logic [15:0] free_bits [16];
    logic        live [16];
    logic [3:0]  order [16];
    int          count;
    logic [3:0]  shift;
  } alloc_state_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [3:0]  in_parent_id;
  logic [3:0]  in_slot;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_granted_parent;
  logic [3:0]  out_granted_slot;
  logic [11:0] out_byte_offset;
  logic        out_parent_opened;
  logic        out_parent_closed;

  alloc_req_t   pending_reqs[$];
  alloc_resp_t  expected_resps[$];
  alloc_state_t dut_state;
  alloc_state_t gen_state;
  alloc_req_t   cur_req;
  int           gap_left;
  bit           gappy;
  int           idle_cycles;
  int           errors;
  int           n_items;
  int           n_no_parent;
  int           n_bad;
  int           n_closed;

  page_table_slot_suballocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_parent_id(in_parent_id), .in_slot(in_slot),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_parent(out_granted_parent), .out_granted_slot(out_granted_slot),
    .out_byte_offset(out_byte_offset), .out_parent_opened(out_parent_opened),
    .out_parent_closed(out_parent_closed)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic [3:0] clamp_shift(logic [3:0] sh);
    if (sh < 4'd8) return 4'd8;
    if (sh > 4'd11) return 4'd11;
    return sh;
  endfunction

  function automatic int slots_per_parent(logic [3:0] sh);
    return 4096 >> clamp_shift(sh);
  endfunction

  function automatic logic [15:0] all_free_mask(logic [3:0] sh);
    logic [16:0] m;
    m = (17'd1 << slots_per_parent(sh)) - 17'd1;
    return m[15:0];
  endfunction

  function automatic void drop_from_list(inout alloc_state_t st, input logic [3:0] p);
    for (int i = 0; i < st.count; i++) begin
      if (st.order[i] == p) begin
        for (int j = i; j + 1 < st.count; j++) st.order[j] = st.order[j+1];
        st.count--;
        return;
      end
    end
  endfunction

  function automatic void push_list_head(inout alloc_state_t st, input logic [3:0] p);
    if (st.count >= 16) return;
    for (int i = st.count; i > 0; i--) st.order[i] = st.order[i-1];
    st.order[0] = p;
    st.count++;
  endfunction

  // advance the allocator by one item and return its result
  function automatic alloc_resp_t alloc_step(inout alloc_state_t st, input alloc_req_t rq);
    alloc_resp_t r;
    logic [3:0]  sh;
    int          p;
    int          s;
    r = '0;
    r.status = ST_OK;
    sh = clamp_shift(st.shift);
    if (rq.action == ACT_GET) begin
      if (st.count == 0) begin
        for (p = 0; p < 16; p++) if (!st.live[p]) break;
        if (p >= 16) begin
          r.status = ST_NO_PARENT;
          return r;
        end
        st.live[p] = 1'b1;
        st.free_bits[p] = all_free_mask(st.shift);
        push_list_head(st, p[3:0]);
        r.opened = 1'b1;
      end else begin
        p = st.order[0];
      end
      for (s = 0; s < 16; s++) if (st.free_bits[p][s]) break;
      if (s >= 16) s = 0;
      st.free_bits[p][s] = 1'b0;
      if (st.free_bits[p] == 16'd0) drop_from_list(st, p[3:0]);
    end else begin
      p = rq.parent_id;
      s = rq.slot;
      if (!st.live[p] || s >= slots_per_parent(st.shift) || st.free_bits[p][s]) begin
        r.status = ST_BAD_RELEASE;
        return r;
      end
      if (st.free_bits[p] == 16'd0) push_list_head(st, p[3:0]);
      st.free_bits[p][s] = 1'b1;
      if (st.free_bits[p] == all_free_mask(st.shift)) begin
        drop_from_list(st, p[3:0]);
        st.live[p] = 1'b0;
        st.free_bits[p] = 16'd0;
        r.closed = 1'b1;
      end
    end
    r.parent = p[3:0];
    r.slot = s[3:0];
    r.offset = 12'((s << sh) & 32'hFFF);
    return r;
  endfunction

  // queue an item and keep the generator's view of the allocator current
  task automatic queue_req(action_t a, logic [3:0] p, logic [3:0] s);
    alloc_req_t  rq;
    alloc_resp_t dummy;
    rq.action = a;
    rq.parent_id = p;
    rq.slot = s;
    dummy = alloc_step(gen_state, rq);
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_idle();
    while (!(pending_reqs.size() == 0 && !start && expected_resps.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_shift(logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_state.shift = v;
  endtask

  // mostly well-formed traffic: gets and releases of held slots, some noise
  task automatic random_phase(int n);
    int get_pct;
    int pp;
    int ss;
    bit found;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) get_pct = $urandom_range(20, 90);
      if ($urandom_range(0, 99) < 8) begin
        queue_req(action_t'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)));
      end else if ($urandom_range(0, 99) < get_pct) begin
        queue_req(ACT_GET, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end else begin
        found = 1'b0;
        for (int t = 0; t < 64 && !found; t++) begin
          pp = $urandom_range(0, 15);
          ss = $urandom_range(0, slots_per_parent(gen_state.shift) - 1);
          if (gen_state.live[pp] && !gen_state.free_bits[pp][ss]) found = 1'b1;
        end
        if (found) queue_req(ACT_PUT, pp[3:0], ss[3:0]);
        else queue_req(ACT_GET, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  // driver: predicts accepted items, then presents the next one after its gap
  always @(posedge clk) begin
    alloc_resp_t r;
    logic        next_start;
    next_start = start;
    if (!rst_n) begin
      next_start = 1'b0;
    end else begin
      if (cfg_we) dut_state.shift = cfg_wdata;
      if (start && !busy) begin
        r = alloc_step(dut_state, cur_req);
        expected_resps.push_back(r);
        n_items++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          next_start = 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_action <= cur_req.action;
          in_parent_id <= cur_req.parent_id;
          in_slot <= cur_req.slot;
          next_start = 1'b1;
          if ($urandom_range(0, 63) == 0) gappy = !gappy;
          gap_left = gappy ? $urandom_range(0, 16) : 0;
        end else begin
          next_start = 1'b0;
        end
      end
      // watchdog on cycles with no traffic at all
      if ((start && !busy) || out_valid || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, expected_resps.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    start <= next_start;
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    alloc_resp_t got;
    alloc_resp_t want;
    if (rst_n && out_valid) begin
      got.status = status_t'(out_status);
      got.parent = out_granted_parent;
      got.slot = out_granted_slot;
      got.offset = out_byte_offset;
      got.opened = out_parent_opened;
      got.closed = out_parent_closed;
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_resps.pop_front();
        if (got.status !== want.status || got.parent !== want.parent ||
            got.slot !== want.slot || got.offset !== want.offset ||
            got.opened !== want.opened || got.closed !== want.closed) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
        if (want.status == ST_NO_PARENT) n_no_parent++;
        if (want.status == ST_BAD_RELEASE) n_bad++;
        if (want.closed) n_closed++;
      end
    end
  end

  initial begin
    logic [3:0] shifts [8];
    shifts = '{4'd8, 4'd11, 4'd9, 4'd0, 4'd10, 4'd15, 4'd3, 4'd13};
    errors = 0; n_items = 0; n_no_parent = 0; n_bad = 0; n_closed = 0;
    idle_cycles = 0; gap_left = 0; gappy = 1'b0;
    rst_n = 1'b0; start = 1'b0; in_action = ACT_GET; in_parent_id = 4'd0; in_slot = 4'd0;
    cfg_we = 1'b0; cfg_wdata = 4'd8;
    for (int i = 0; i < 16; i++) begin
      dut_state.free_bits[i] = 16'd0; dut_state.live[i] = 1'b0; dut_state.order[i] = 4'd0;
    end
    dut_state.count = 0;
    dut_state.shift = 4'd8;
    gen_state = dut_state;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: opens, grants, releases, bad releases, close on all free
    queue_req(ACT_GET, 4'd0, 4'd0);
    queue_req(ACT_GET, 4'd15, 4'd15);
    queue_req(ACT_PUT, 4'd0, 4'd1);
    queue_req(ACT_PUT, 4'd0, 4'd1);
    queue_req(ACT_PUT, 4'd5, 4'd0);
    queue_req(ACT_PUT, 4'd15, 4'd15);
    queue_req(ACT_GET, 4'd0, 4'd0);
    queue_req(ACT_PUT, 4'd0, 4'd15);
    queue_req(ACT_PUT, 4'd0, 4'd1);
    queue_req(ACT_PUT, 4'd0, 4'd0);
    queue_req(ACT_PUT, 4'd0, 4'd0);
    wait_idle();
    // smallest slot count: drain every parent until none is left
    write_shift(4'd11);
    for (int i = 0; i < 34; i++) queue_req(ACT_GET, 4'd0, 4'd0);
    queue_req(ACT_PUT, 4'd15, 4'd1);
    queue_req(ACT_PUT, 4'd15, 4'd2);
    queue_req(ACT_GET, 4'd0, 4'd0);
    wait_idle();

    foreach (shifts[i]) begin
      write_shift(shifts[i]);
      random_phase(RAND_PER_PHASE);
      wait_idle();
    end
    repeat (8) @(posedge clk);

    $display("%0d items: %0d with no parent left, %0d bad releases, %0d parents closed",
             n_items, n_no_parent, n_bad, n_closed);
    $display("slot shifts covered 8..11 plus clamped values 0, 3, 13 and 15");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
